[rtl/core/sha_pkg.sv]
`default_nettype none
package sha_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned ResDepth  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadMark     = 8'h80;
  localparam logic [5:0] LenFieldPos = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[rtl/core/sha_fifo.sv]
`default_nettype none
module sha_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o  = (cnt_q == Cw'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_rd) begin
      rp_d = (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

[rtl/core/sha_engine.sv]
`default_nettype none
module sha_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire sha_pkg::item_t item_i,
  output logic               item_take_o,
  input  wire logic [3:0]    res_count_i,
  output logic               res_push_o,
  output logic [35:0]        res_data_o
);
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StRound = 6'b000100,
    StAdd   = 6'b001000,
    StWait  = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [2:0]  emit_q;
  logic        fin_q;
  logic        second_q;
  logic        padded_q;
  logic [5:0]  pad_pos_q;

  logic [31:0] s0, s1, wn, t1, t2, wr_word;
  logic [1:0]  lane;

  always_comb begin
    s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = s1 + w_q[9] + s0 + w_q[0];
    t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
         ^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + sha_pkg::RoundK[rnd_q] + w_q[0];
    t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
         ^ sha_pkg::rotr(v_q[0], 22))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign item_take_o = (state_q == StIdle) && item_valid_i;
  assign res_push_o  = (state_q == StEmit);
  assign res_data_o  = {h_q[emit_q], emit_q, emit_q == 3'd7};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          if (item_i.present && fill_q == 6'd63) begin
            state_d = StRound;
          end else if (item_i.last) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (pad_pos_q == 6'd63) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        if (fin_q && !padded_q) begin
          state_d = StPad;
        end else if (fin_q && !second_q && fill_q > 6'd55) begin
          state_d = StPad;
        end else if (fin_q) begin
          state_d = StWait;
        end else begin
          state_d = StIdle;
        end
      end
      StWait: begin
        if (res_count_i == 4'd0) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_q == 3'd7) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    lane    = pad_pos_q[1:0];
    wr_word = w_q[pad_pos_q[5:2]];
    if (pad_pos_q == fill_q && !second_q) begin
      wr_word[8*(3-lane) +: 8] = sha_pkg::PadMark;
    end else if (pad_pos_q >= sha_pkg::LenFieldPos && !(fill_q > 6'd55 && !second_q)) begin
      wr_word[8*(3-lane) +: 8] = bits_q[8*(7 - pad_pos_q[2:0]) +: 8];
    end else begin
      wr_word[8*(3-lane) +: 8] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      bits_q    <= '0;
      rnd_q     <= '0;
      emit_q    <= '0;
      fin_q     <= 1'b0;
      second_q  <= 1'b0;
      padded_q  <= 1'b0;
      pad_pos_q <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::InitHash[i];
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            fin_q <= item_i.last;
            if (item_i.present) begin
              fill_q <= fill_q + 1'b1;
              bits_q <= bits_q + 64'd8;
            end
            pad_pos_q <= item_i.present ? fill_q + 1'b1 : fill_q;
            second_q  <= 1'b0;
            padded_q  <= 1'b0;
          end
        end
        StPad: begin
          pad_pos_q <= pad_pos_q + 1'b1;
          padded_q  <= 1'b1;
        end
        StRound: begin
          rnd_q <= rnd_q + 1'b1;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          if (fin_q && padded_q && !second_q && fill_q > 6'd55) begin
            second_q  <= 1'b1;
            pad_pos_q <= '0;
          end else if (second_q) begin
            second_q <= 1'b0;
          end
        end
        StEmit: begin
          emit_q <= emit_q + 1'b1;
          if (emit_q == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= sha_pkg::InitHash[i];
            end
            fill_q <= '0;
            bits_q <= '0;
            fin_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && item_valid_i && item_i.present) begin
      w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= item_i.data;
      if (fill_q == 6'd63) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= h_q[i];
        end
      end
    end
    if (state_q == StPad) begin
      w_q[pad_pos_q[5:2]] <= wr_word;
      if (pad_pos_q == 6'd63) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= h_q[i];
        end
      end
    end
    if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wn;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

[rtl/core/sha256_byte_stream_hasher_core.sv]
// SHA-256 over a byte stream.
// Input queue: drive data_byte_i, byte_present_i, last_byte_i with push; a
// word is taken when push is high and full is low. A word with
// byte_present_i low and last_byte_i low is dropped.
// Result queue: while empty is low the oldest digest word is on
// digest_word_o, word_index_o and last_word_o; pop takes it.
// A four-entry queue holds input words while the engine compresses.
// The engine takes each byte into the block; the 64th byte of a block starts
// a compression (64 rounds, one add). A last word pads the bytes left in the
// block and compresses it; a second padding block follows when more than 55
// bytes are pending. When the last byte fills the block, a padding block
// follows its compression. The engine then waits until the result queue is
// drained and writes the eight digest words in order.
// If the receiver stalls, digests stay queued and the engine holds before its
// next digest; input keeps filling the four-entry queue until full.
// Reset empties both queues and loads the initial hash values.
`default_nettype none
module sha256_byte_stream_hasher_core #(
  parameter int unsigned FifoDepth = sha_pkg::FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        last_byte_i,
  input  wire logic        push,
  output logic             full,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output logic             empty,
  input  wire logic        pop
);
  sha_pkg::item_t in_item, q_item;
  logic q_empty, take, rpush, eng_take, rfull;
  logic [35:0] rdata, odata;
  logic [3:0] rcount;
  logic [$clog2(FifoDepth+1)-1:0] icount;

  assign in_item = '{data: data_byte_i, present: byte_present_i, last: last_byte_i};

  sha_fifo #(.Width($bits(sha_pkg::item_t)), .Depth(FifoDepth)) u_in (
    .clk_i, .rst_ni, .wr_i(push), .wdata_i(in_item), .full_o(full),
    .rd_i(take), .rdata_o(q_item), .empty_o(q_empty), .count_o(icount)
  );

  sha_engine u_eng (
    .clk_i, .rst_ni, .item_valid_i(!q_empty && (q_item.present || q_item.last)),
    .item_i(q_item), .item_take_o(eng_take), .res_count_i(rcount),
    .res_push_o(rpush), .res_data_o(rdata)
  );

  assign take = !q_empty && (!(q_item.present || q_item.last) || eng_take);

  sha_fifo #(.Width(36), .Depth(sha_pkg::ResDepth)) u_out (
    .clk_i, .rst_ni, .wr_i(rpush), .wdata_i(rdata), .full_o(rfull),
    .rd_i(pop), .rdata_o(odata), .empty_o(empty), .count_o(rcount)
  );

  assign digest_word_o = odata[35:4];
  assign word_index_o  = odata[3:1];
  assign last_word_o   = odata[0];

`ifndef NO_ASSERTIONS
  a_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    icount <= FifoDepth) else $error("input queue overrun");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpush |-> !rfull) else $error("result queue overrun");
`endif
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        empty;
  logic        pop = 1'b0;

  sha256_byte_stream_hasher_core u_top (
    .clk_i, .rst_ni, .data_byte_i, .byte_present_i, .last_byte_i,
    .push, .full, .digest_word_o, .word_index_o, .last_word_o, .empty, .pop
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        has_digest;
    logic [31:0] first_word;
  } stim_row_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   block_store [64];
  logic [5:0]   fill_level;
  logic [63:0]  bit_length;
  digest_word_t pending_digest [$];
  logic [31:0]  first_word_hint [$];
  bit           hint_known [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           calm_phase = 1'b0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_store[4*i], block_store[4*i+1], block_store[4*i+2], block_store[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitHash[i];
    fill_level = '0;
    bit_length = '0;
  endtask

  task automatic absorb_word(logic [7:0] data, logic present, logic last);
    int pos;
    if (present) begin
      block_store[fill_level] = data;
      fill_level++;
      bit_length += 64'd8;
      if (fill_level == 0) compress_block();
    end
    if (!last) return;
    pos = fill_level;
    block_store[pos] = sha_pkg::PadMark;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        block_store[pos] = '0;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_store[pos] = '0;
      pos++;
    end
    for (int k = 0; k < 8; k++) block_store[56 + k] = bit_length[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++)
      pending_digest.push_back('{hash_state[k], 3'(k), k == 7});
    restart_hash();
  endtask

  always @(posedge clk_i) begin
    digest_word_t exp_word;
    if (rst_ni && pop && !empty) begin
      if (pending_digest.size() == 0) begin
        $error("unexpected digest word %h", digest_word_o);
        fail_count++;
      end else begin
        exp_word = pending_digest.pop_front();
        if (exp_word.index == 0 && first_word_hint.size() > 0) begin
          if (hint_known[0] && first_word_hint[0] !== digest_word_o) begin
            $error("digest_word: expected %h actual %h", first_word_hint[0], digest_word_o);
            fail_count++;
          end
          void'(first_word_hint.pop_front());
          void'(hint_known.pop_front());
        end
        if (digest_word_o !== exp_word.word) begin
          $error("digest_word: expected %h actual %h", exp_word.word, digest_word_o);
          fail_count++;
        end
        if (word_index_o !== exp_word.index) begin
          $error("word_index: expected %0d actual %0d", exp_word.index, word_index_o);
          fail_count++;
        end
        if (last_word_o !== exp_word.last) begin
          $error("last_word: expected %0d actual %0d", exp_word.last, last_word_o);
          fail_count++;
        end
      end
    end
  end

  int sink_stall = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (calm_phase) begin
      pop <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(logic [7:0] data, logic present, logic last);
    int gap;
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= data;
    byte_present_i <= present;
    last_byte_i <= last;
    do @(posedge clk_i); while (full);
    absorb_word(data, present, last);
  endtask

  stim_row_t directed_rows [9] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  task automatic send_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom), 1'b1, end_with_byte && i == len - 1);
    if (!end_with_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  int sent;
  int len;
  initial begin
    restart_hash();
    for (int i = 0; i < 64; i++) block_store[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r]) begin
      if (directed_rows[r].last) begin
        first_word_hint.push_back(directed_rows[r].first_word);
        hint_known.push_back(directed_rows[r].has_digest);
      end
      send_word(directed_rows[r].data, directed_rows[r].present, directed_rows[r].last);
    end
    send_message(56, 1'b1);
    send_message(64, 1'b1);
    sent = 0;
    while (sent < 50) begin
      if (sent > 35) calm_phase = 1'b1;
      case ($urandom_range(0, 9))
        0: begin send_word(8'($urandom), 1'b0, 1'b0); end
        1: begin send_word(8'($urandom), 1'($urandom), 1'($urandom)); sent++; end
        default: begin
          len = $urandom_range(0, 12);
          send_message(len, 1'($urandom));
          sent += len + 1;
        end
      endcase
    end
    push <= 1'b0;
    calm_phase = 1'b1;
    while (pending_digest.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending_digest.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
